FILE: src/tspb_pkg.sv
package tspb_pkg;

  localparam int unsigned TEMP_W  = 19;
  localparam int unsigned FREQ_W  = 5;
  localparam int unsigned DUTY_W  = 7;
  localparam int unsigned PHASE_W = 10;
  localparam int unsigned CFG_IW  = 3;
  localparam int unsigned LEVELS  = 4;

  // shared divider: dividend covers P * duty, divisor covers freq and 100
  localparam int unsigned DVD_W = PHASE_W + DUTY_W;
  localparam int unsigned DVS_W = DUTY_W;

  localparam logic [FREQ_W-1:0]  MAN_FREQ_LO = 5'd1;
  localparam logic [FREQ_W-1:0]  MAN_FREQ_HI = 5'd20;
  localparam logic [FREQ_W-1:0]  FREQ_RESET  = 5'd5;
  localparam logic [DUTY_W-1:0]  DUTY_FULL   = 7'd100;
  localparam logic [DVD_W-1:0]   PERIOD_BASE = 17'd1000;

  localparam logic [FREQ_W-1:0] LEVEL_FREQ [LEVELS] = '{5'd20, 5'd10, 5'd5, 5'd2};

  localparam logic signed [TEMP_W-1:0] THR_HIGH_RST = 19'sd45000;
  localparam logic signed [TEMP_W-1:0] THR_MID_RST  = 19'sd40000;
  localparam logic signed [TEMP_W-1:0] THR_LOW_RST  = 19'sd35000;
  localparam logic [DUTY_W-1:0]        DUTY_RST     = 7'd50;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MODE     = 3'd0,
    CFG_MAN_FREQ = 3'd1,
    CFG_DUTY     = 3'd2,
    CFG_THR_HIGH = 3'd3,
    CFG_THR_MID  = 3'd4,
    CFG_THR_LOW  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_P,
    ST_DIV_P,
    ST_LOAD_H,
    ST_DIV_H,
    ST_WB
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: src/tspb_if.sv
interface tspb_in_if import tspb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic signed [TEMP_W-1:0] temp_milli;

  modport source (output valid, cmd, temp_milli, input ready);
  modport sink   (input valid, cmd, temp_milli, output ready);
endinterface

interface tspb_out_if import tspb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               led_level;
  logic [FREQ_W-1:0]  freq_in_use;
  logic [PHASE_W-1:0] phase_left;

  modport source (output valid, led_level, freq_in_use, phase_left, input ready);
  modport sink   (input valid, led_level, freq_in_use, phase_left, output ready);
endinterface

FILE: src/thermal_stepped_pwm_blinker_core.sv
// channel  dir  words                            handshake
// in_i     in   cmd (tick/sample), temp_milli    valid/ready
// out_o    out  led_level, freq_in_use,          valid/ready
//               phase_left
// cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i write only, no stall
//
// A sample or a mid-phase tick is taken when ready is high, its word valid the next cycle.
// A phase-end tick holds the input through accept, two passes of the shared
// restoring divider (1000 / f, then P * duty / 100), then write-back.
// Reset (async, active low): default registers, pin low, phase count 0, auto 5 Hz.
// in_i.ready drops while a phase-end word is in flight or while the output
// register holds a word that is not taken; write-back waits on the same.
module thermal_stepped_pwm_blinker_core import tspb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tspb_in_if.sink           in_i,
  tspb_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [TEMP_W-1:0] cfg_wdata_i
);

  // configuration
  logic                     mode_q;
  logic [FREQ_W-1:0]        manual_freq_q;
  logic [DUTY_W-1:0]        duty_q;
  logic signed [TEMP_W-1:0] thr_high_q, thr_mid_q, thr_low_q;

  // block state
  state_e             state_q, state_d;
  logic               pin_q, pin_d;
  logic [PHASE_W-1:0] count_q, count_d;
  logic [FREQ_W-1:0]  auto_freq_q, auto_freq_d;
  logic [PHASE_W-1:0] p_q, p_d;
  logic [PHASE_W-1:0] h_q, h_d;
  logic [DVD_W-1:0]   prod_q, prod_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               out_led_q, out_led_d;
  logic [FREQ_W-1:0]  out_freq_q, out_freq_d;
  logic [PHASE_W-1:0] out_phase_q, out_phase_d;

  logic               slot_free;
  logic               accept;
  logic               commit;
  logic [FREQ_W-1:0]  freq_now, freq_pick;
  logic [DUTY_W-1:0]  duty_sat;
  logic [PHASE_W-1:0] lo_len;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  tspb_freq_sel u_freq_sel (
    .mode_i        (mode_q),
    .manual_freq_i (manual_freq_q),
    .auto_freq_i   (auto_freq_q),
    .duty_i        (duty_q),
    .temp_i        (in_i.temp_milli),
    .thr_high_i    (thr_high_q),
    .thr_mid_i     (thr_mid_q),
    .thr_low_i     (thr_low_q),
    .freq_now_o    (freq_now),
    .freq_pick_o   (freq_pick),
    .duty_sat_o    (duty_sat)
  );

  tspb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign slot_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_i.valid && in_i.ready;
  assign commit     = (state_q == ST_WB) && slot_free;
  assign lo_len     = p_q - h_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && in_i.cmd == CMD_TICK && count_q <= PHASE_W'(1)) begin
          state_d = ST_LOAD_P;
        end
      end
      ST_LOAD_P: state_d = ST_DIV_P;
      ST_DIV_P: begin
        if (div_rsp.done) begin
          state_d = ST_LOAD_H;
        end
      end
      ST_LOAD_H: state_d = ST_DIV_H;
      ST_DIV_H: begin
        if (div_rsp.done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    div_req     = '0;
    pin_d       = pin_q;
    count_d     = count_q;
    auto_freq_d = auto_freq_q;
    p_d         = p_q;
    h_d         = h_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_led_d   = out_led_q;
    out_freq_d  = out_freq_q;
    out_phase_d = out_phase_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_SAMPLE) begin
            out_valid_d = 1'b1;
            out_led_d   = pin_q;
            out_phase_d = count_q;
            if (!mode_q) begin
              auto_freq_d = freq_pick;
              out_freq_d  = freq_pick;
            end else begin
              out_freq_d = freq_now;
            end
          end else if (count_q > PHASE_W'(1)) begin
            count_d     = count_q - 1'b1;
            out_valid_d = 1'b1;
            out_led_d   = pin_q;
            out_freq_d  = freq_now;
            out_phase_d = count_q - 1'b1;
          end
        end
      end
      ST_LOAD_P: begin
        div_req.start    = 1'b1;
        div_req.dividend = PERIOD_BASE;
        div_req.divisor  = DVS_W'(freq_now);
      end
      ST_DIV_P: begin
        if (div_rsp.done) begin
          p_d    = div_rsp.quot[PHASE_W-1:0];
          prod_d = DVD_W'(div_rsp.quot[PHASE_W-1:0]) * DVD_W'(duty_sat);
        end
      end
      ST_LOAD_H: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_q;
        div_req.divisor  = DUTY_FULL;
      end
      ST_DIV_H: begin
        if (div_rsp.done) begin
          h_d = div_rsp.quot[PHASE_W-1:0];
        end
      end
      ST_WB: begin
        if (commit) begin
          // toggle; a zero-length phase is skipped by toggling back
          if (!pin_q) begin
            pin_d   = (h_q != '0);
            count_d = (h_q != '0) ? h_q : lo_len;
          end else begin
            pin_d   = (lo_len == '0);
            count_d = (lo_len != '0) ? lo_len : h_q;
          end
          out_valid_d = 1'b1;
          out_led_d   = pin_d;
          out_freq_d  = freq_now;
          out_phase_d = count_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pin_q       <= 1'b0;
      count_q     <= '0;
      auto_freq_q <= FREQ_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pin_q       <= pin_d;
      count_q     <= count_d;
      auto_freq_q <= auto_freq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    h_q         <= h_d;
    prod_q      <= prod_d;
    out_led_q   <= out_led_d;
    out_freq_q  <= out_freq_d;
    out_phase_q <= out_phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      manual_freq_q <= FREQ_RESET;
      duty_q        <= DUTY_RST;
      thr_high_q    <= THR_HIGH_RST;
      thr_mid_q     <= THR_MID_RST;
      thr_low_q     <= THR_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:     mode_q        <= cfg_wdata_i[0];
        CFG_MAN_FREQ: manual_freq_q <= cfg_wdata_i[FREQ_W-1:0];
        CFG_DUTY:     duty_q        <= cfg_wdata_i[DUTY_W-1:0];
        CFG_THR_HIGH: thr_high_q    <= cfg_wdata_i;
        CFG_THR_MID:  thr_mid_q     <= cfg_wdata_i;
        CFG_THR_LOW:  thr_low_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.led_level   = out_led_q;
  assign out_o.freq_in_use = out_freq_q;
  assign out_o.phase_left  = out_phase_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PHASE_W'(1000))
    else $error("phase count above one period");

  a_wb_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> count_q != '0)
    else $error("phase end loaded a zero length");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV_P || state_q == ST_DIV_H))
    else $error("divider finished outside a divide state");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> !in_i.ready)
    else $error("input ready while divider busy");
`endif

endmodule

FILE: src/tspb_div.sv
module tspb_div import tspb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one restoring step per cycle; quotient bits shift in at the bottom
  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = dvd_q;

endmodule

FILE: src/tspb_freq_sel.sv
module tspb_freq_sel import tspb_pkg::*; (
  input  logic                     mode_i,
  input  logic [FREQ_W-1:0]        manual_freq_i,
  input  logic [FREQ_W-1:0]        auto_freq_i,
  input  logic [DUTY_W-1:0]        duty_i,
  input  logic signed [TEMP_W-1:0] temp_i,
  input  logic signed [TEMP_W-1:0] thr_high_i,
  input  logic signed [TEMP_W-1:0] thr_mid_i,
  input  logic signed [TEMP_W-1:0] thr_low_i,
  output logic [FREQ_W-1:0]        freq_now_o,
  output logic [FREQ_W-1:0]        freq_pick_o,
  output logic [DUTY_W-1:0]        duty_sat_o
);

  always_comb begin
    if (mode_i) begin
      if (manual_freq_i < MAN_FREQ_LO) begin
        freq_now_o = MAN_FREQ_LO;
      end else if (manual_freq_i > MAN_FREQ_HI) begin
        freq_now_o = MAN_FREQ_HI;
      end else begin
        freq_now_o = manual_freq_i;
      end
    end else begin
      freq_now_o = (auto_freq_i < MAN_FREQ_LO) ? MAN_FREQ_LO : auto_freq_i;
    end
  end

  // thresholds checked top down, first hit wins even if unordered
  always_comb begin
    if (temp_i >= thr_high_i) begin
      freq_pick_o = LEVEL_FREQ[0];
    end else if (temp_i >= thr_mid_i) begin
      freq_pick_o = LEVEL_FREQ[1];
    end else if (temp_i >= thr_low_i) begin
      freq_pick_o = LEVEL_FREQ[2];
    end else begin
      freq_pick_o = LEVEL_FREQ[LEVELS-1];
    end
  end

  assign duty_sat_o = (duty_i > DUTY_FULL) ? DUTY_FULL : duty_i;

endmodule

FILE: verif/thermal_stepped_pwm_blinker_core_tb.sv
`timescale 1ns / 100ps

import tspb_pkg::*;

typedef struct packed {
  logic               led;
  logic [FREQ_W-1:0]  freq;
  logic [PHASE_W-1:0] left;
} blink_word_t;

class blink_scoreboard;
  // register copies
  bit                       mode;
  logic [FREQ_W-1:0]        man_freq;
  logic [DUTY_W-1:0]        duty;
  logic signed [TEMP_W-1:0] thr_hi;
  logic signed [TEMP_W-1:0] thr_mid;
  logic signed [TEMP_W-1:0] thr_lo;
  // blinker state
  bit                       pin;
  int unsigned              phase_cnt;
  int unsigned              auto_freq;

  blink_word_t expected_words[$];
  int unsigned errors, checked, ticks, samples, phase_ends, skips;

  function new();
    mode      = 1'b0;
    man_freq  = 5;
    duty      = 50;
    thr_hi    = 45000;
    thr_mid   = 40000;
    thr_lo    = 35000;
    pin       = 1'b0;
    phase_cnt = 0;
    auto_freq = 5;
  endfunction

  function void set_reg(cfg_idx_e idx, logic [TEMP_W-1:0] val);
    case (idx)
      CFG_MODE:     mode = val[0];
      CFG_MAN_FREQ: man_freq = val[FREQ_W-1:0];
      CFG_DUTY:     duty = val[DUTY_W-1:0];
      CFG_THR_HIGH: thr_hi = val;
      CFG_THR_MID:  thr_mid = val;
      CFG_THR_LOW:  thr_lo = val;
      default: ;
    endcase
  endfunction

  function int unsigned freq_now();
    int unsigned f;
    if (mode) begin
      f = man_freq;
      if (f < 1) f = 1;
      if (f > 20) f = 20;
    end else begin
      f = auto_freq;
    end
    return f;
  endfunction

  function int unsigned phase_len(bit lvl);
    int unsigned p, d, hi;
    p  = 1000 / freq_now();
    d  = (duty > 100) ? 100 : duty;
    hi = p * d / 100;
    return lvl ? hi : p - hi;
  endfunction

  function void note_input(cmd_e cmd, logic signed [TEMP_W-1:0] temp);
    int unsigned len;
    blink_word_t w;
    if (cmd == CMD_SAMPLE) begin
      samples++;
      if (!mode) begin
        // first threshold met wins, even when they are out of order
        if (temp >= thr_hi)       auto_freq = 20;
        else if (temp >= thr_mid) auto_freq = 10;
        else if (temp >= thr_lo)  auto_freq = 5;
        else                      auto_freq = 2;
      end
    end else begin
      ticks++;
      if (phase_cnt > 1) begin
        phase_cnt--;
      end else begin
        phase_ends++;
        pin = ~pin;
        len = phase_len(pin);
        if (len == 0) begin
          skips++;
          pin = ~pin;
          len = phase_len(pin);
        end
        phase_cnt = len;
      end
    end
    len    = freq_now();
    w.led  = pin;
    w.freq = len[FREQ_W-1:0];
    w.left = phase_cnt[PHASE_W-1:0];
    expected_words.push_back(w);
  endfunction

  function void check_result(logic led, logic [FREQ_W-1:0] freq, logic [PHASE_W-1:0] left);
    blink_word_t w;
    if (expected_words.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word: led %0d freq %0d left %0d", led, freq, left);
      return;
    end
    w = expected_words.pop_front();
    checked++;
    if (led !== w.led || freq !== w.freq || left !== w.left) begin
      errors++;
      if (errors <= 10)
        $display("word %0d: exp led %0d freq %0d left %0d, got led %0d freq %0d left %0d",
                 checked, w.led, w.freq, w.left, led, freq, left);
    end
  endfunction
endclass

module thermal_stepped_pwm_blinker_core_tb;

  localparam int unsigned HOLD_CYCLES = 400;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [TEMP_W-1:0] cfg_wdata;

  tspb_in_if  in_if ();
  tspb_out_if out_if ();

  thermal_stepped_pwm_blinker_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  blink_scoreboard sb = new();

  bit          hold_req;
  int unsigned hold_cnt;
  int unsigned seg_left;
  int unsigned ready_pct;
  int unsigned settings;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: checks taken words and stalls on its own pattern
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.led_level, out_if.freq_in_use, out_if.phase_left);
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(200, 20);
        case ($urandom_range(3))
          0:       ready_pct = 100;
          1:       ready_pct = 75;
          2:       ready_pct = 50;
          default: ready_pct = 15;
        endcase
      end
      seg_left--;
      out_if.ready <= ($urandom_range(99) < ready_pct);
    end
  end

  task automatic send_word(cmd_e cmd, logic [TEMP_W-1:0] temp);
    in_if.valid      <= 1'b1;
    in_if.cmd        <= cmd;
    in_if.temp_milli <= temp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(cmd, temp);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TEMP_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(bit md, logic [FREQ_W-1:0] f, logic [DUTY_W-1:0] d,
                              logic signed [TEMP_W-1:0] hi, logic signed [TEMP_W-1:0] mid,
                              logic signed [TEMP_W-1:0] lo);
    write_reg(CFG_MODE, TEMP_W'(md));
    write_reg(CFG_MAN_FREQ, TEMP_W'(f));
    write_reg(CFG_DUTY, TEMP_W'(d));
    write_reg(CFG_THR_HIGH, hi);
    write_reg(CFG_THR_MID, mid);
    write_reg(CFG_THR_LOW, lo);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [TEMP_W-1:0] pick_temp();
    int t;
    case ($urandom_range(9))
      0: t = $urandom;
      1, 2: begin
        // right at a threshold or one off
        case ($urandom_range(2))
          0:       t = int'(sb.thr_hi);
          1:       t = int'(sb.thr_mid);
          default: t = int'(sb.thr_lo);
        endcase
        t = t + int'($urandom_range(2)) - 1;
      end
      3, 4, 5: t = int'($urandom_range(190000)) - 40000;
      default: t = int'($urandom_range(150000, 30000));
    endcase
    return t[TEMP_W-1:0];
  endfunction

  task automatic run_traffic(int unsigned n_items, int unsigned tick_pct);
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(24, 1);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < tick_pct)
        send_word(CMD_TICK, TEMP_W'($urandom));
      else
        send_word(CMD_SAMPLE, pick_temp());
      burst--;
      if (burst == 0) begin
        burst = ($urandom_range(4) == 0) ? 60 : $urandom_range(24, 1);
        gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
        if (gap != 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    int unsigned d_pick;
    logic [DUTY_W-1:0] d;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_MODE;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_TICK;
    in_if.temp_milli = '0;
    out_if.ready     = 1'b0;
    hold_req         = 1'b0;
    hold_cnt         = 0;
    seg_left         = 0;
    settings         = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // thresholds and field extremes under reset settings
    send_word(CMD_SAMPLE, 19'sd45000);
    send_word(CMD_SAMPLE, 19'sd44999);
    send_word(CMD_SAMPLE, 19'sd40000);
    send_word(CMD_SAMPLE, 19'sd39999);
    send_word(CMD_SAMPLE, 19'sd35000);
    send_word(CMD_SAMPLE, 19'sd34999);
    send_word(CMD_TICK, '1);
    send_word(CMD_SAMPLE, -19'sd40000);
    send_word(CMD_SAMPLE, 19'h40000);
    send_word(CMD_TICK, '0);
    send_word(CMD_SAMPLE, 19'h3FFFF);
    send_word(CMD_SAMPLE, 19'sd150000);
    send_word(CMD_TICK, '0);
    send_word(CMD_TICK, '0);
    send_word(CMD_TICK, 19'h2AAAA);
    drain();

    // manual, clamped high and zero duty: the high phase is empty
    program_regs(1'b1, 5'd31, 7'd0, 19'sd45000, 19'sd40000, 19'sd35000);
    run_traffic(90, 90);
    drain();

    // full-scale 20 Hz duty: low phase empty
    program_regs(1'b1, 5'd20, 7'd100, 19'sd45000, 19'sd40000, 19'sd35000);
    run_traffic(90, 90);
    drain();

    // out-of-order thresholds at the 19-bit extremes; receiver holds off meanwhile
    program_regs(1'b0, 5'd0, 7'd127, 19'sh3FFFF, 19'sh40000, 19'sd150000);
    hold_req = 1'b1;
    run_traffic(90, 80);
    drain();

    program_regs(1'b0, 5'd7, 7'd50, -19'sd40000, 19'sd150000, 19'sd0);
    run_traffic(90, 80);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      d_pick = $urandom_range(5);
      case (d_pick)
        0:       d = 7'd0;
        1:       d = 7'd100;
        2:       d = 7'd127;
        default: d = DUTY_W'($urandom_range(127));
      endcase
      program_regs(1'($urandom_range(1)), FREQ_W'($urandom_range(31)), d,
                   TEMP_W'(int'($urandom_range(190000)) - 40000),
                   TEMP_W'(int'($urandom_range(190000)) - 40000),
                   TEMP_W'(int'($urandom_range(190000)) - 40000));
      run_traffic(90, 85);
      drain();
    end

    // short phases first so the 1 Hz full-duty phase is reached
    program_regs(1'b1, 5'd20, 7'd50, 19'sd45000, 19'sd40000, 19'sd35000);
    run_traffic(60, 90);
    drain();

    // 1 Hz at full duty: longest phase, low phase skipped
    program_regs(1'b1, 5'd1, 7'd100, 19'sd45000, 19'sd40000, 19'sd35000);
    run_traffic(100, 95);
    drain();

    repeat (60) @(posedge clk);
    $display("stimulus: %0d ticks, %0d samples across %0d register settings",
             sb.ticks, sb.samples, settings);
    $display("%0d phase ends seen, %0d skipped an empty phase; %0d words checked",
             sb.phase_ends, sb.skips, sb.checked);
    if (sb.errors == 0 && sb.expected_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/tspb_pkg.sv
src/tspb_if.sv
src/tspb_div.sv
src/tspb_freq_sel.sv
src/thermal_stepped_pwm_blinker_core.sv
verif/thermal_stepped_pwm_blinker_core_tb.sv
